### rtl/cwuts_pkg.sv
// Shared types, constants and the known-tag lookup for the chunk walker tag scanner.
// No dependencies; imported by every module under rtl.
package cwuts_pkg;

    localparam int unsigned NUM_TABLE  = 31;
    localparam int unsigned KNOWN_TAGS = 31;
    localparam int unsigned CHECKED    = (KNOWN_TAGS < NUM_TABLE) ? KNOWN_TAGS : NUM_TABLE;

    localparam int unsigned OUTQ_DEPTH = 2;
    localparam int unsigned OUTQ_PTR_W = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
    localparam int unsigned OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    localparam logic [2:0] HDR_LAST_TAG = 3'd3;
    localparam logic [2:0] HDR_LAST_LEN = 3'd7;

    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] offset;
    } t_cand;

    typedef logic [31:0] t_tag_table [NUM_TABLE];

    // first letter sits in bits 31:24
    localparam t_tag_table TAG_TABLE = '{
        "MVER",
        "MOHD", "MOTX", "MOMT", "MOGN", "MOGI", "MOSB",
        "MOPV", "MOPT", "MOPR", "MOVV", "MOVB", "MOLT",
        "MODS", "MODN", "MODD", "MFOG", "MCVP",
        "MOGP", "MOPY", "MOVI", "MOVT", "MONR", "MOTV",
        "MOBA", "MOLR", "MODR", "MOBN", "MOBR", "MOCV",
        "MLIQ"
    };

    function automatic logic tag_is_known(input logic [31:0] tag);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < int'(CHECKED); i++) begin
            if (TAG_TABLE[i] == tag) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

### rtl/chunk_walker_unknown_tag_scan.sv
// Top level of the chunk walker tag scanner: walker, tag compare and result queue.
// Depends on cwuts_pkg, cwuts_walker, cwuts_match and cwuts_out_q.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one file byte per item plus a
//   first-byte flag that restarts the offset and the header walk at offset 0.
//   Output channel (o_out_valid / i_out_ready) carries one item per chunk whose
//   4-byte little-endian tag is not in the known-tag table: the tag and the
//   offset of its header. Length bytes set the payload skip; offsets and
//   lengths wrap at 32 bits.
// Throughput: one byte per cycle while o_in_ready is high. A tag completed by an
//   accepted byte sits in the candidate register, is compared the next cycle and
//   is written into the queue, from which the receiver can then take it.
// Stall: results wait in a two-entry queue. o_in_ready drops only while the
//   queue plus the compare register hold two items, so a stalled receiver
//   back-pressures the input after at most two pending results.
// Reset: synchronous, active low; clears the walk state and empties the queue,
//   so the first byte after reset is header byte 0 at offset 0.
module chunk_walker_unknown_tag_scan
    import cwuts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_unknown_tag,
    output logic [31:0] o_chunk_offset
);

    logic                  accept;
    logic                  cand_valid;
    t_cand                 cand;
    logic                  push;
    t_cand                 push_data;
    t_cand                 q_data;
    logic [OUTQ_CNT_W-1:0] q_count;
    logic [OUTQ_CNT_W:0]   pending;

    assign pending    = {1'b0, q_count} + (OUTQ_CNT_W + 1)'(cand_valid);
    assign o_in_ready = pending < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH);
    assign accept     = i_in_valid && o_in_ready;

    cwuts_walker u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .o_cand_valid (cand_valid),
        .o_cand       (cand)
    );

    cwuts_match u_match (
        .i_cand_valid (cand_valid),
        .i_cand       (cand),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    cwuts_out_q u_out_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_data      (q_data),
        .o_count     (q_count)
    );

    assign o_unknown_tag  = q_data.tag;
    assign o_chunk_offset = q_data.offset;

    // queued plus in-flight results never exceed the queue depth
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pending <= (OUTQ_CNT_W + 1)'(OUTQ_DEPTH))
        else $error("pending results exceed queue depth");

endmodule

### rtl/cwuts_walker.sv
// Header walker: tracks offset, header bytes and payload skip for each accepted byte.
// Registers a candidate tag with its header offset when a tag completes. Uses cwuts_pkg.
module cwuts_walker
    import cwuts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    output logic        o_cand_valid,
    output t_cand       o_cand
);

    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_len, n_len;
    logic [31:0] r_skip, n_skip;
    logic [31:0] r_offset, n_offset;
    logic [31:0] r_hdr_start, n_hdr_start;
    logic        r_cand_valid, n_cand_valid;
    t_cand       r_cand, n_cand;

    logic [2:0]  e_hdr_cnt;
    logic [31:0] e_tag, e_len, e_skip, e_offset;

    always_comb begin
        // a new file restarts the walk at offset 0
        e_hdr_cnt = i_first_byte ? 3'd0  : r_hdr_cnt;
        e_tag     = i_first_byte ? '0    : r_tag;
        e_len     = i_first_byte ? '0    : r_len;
        e_skip    = i_first_byte ? '0    : r_skip;
        e_offset  = i_first_byte ? '0    : r_offset;

        n_hdr_cnt    = r_hdr_cnt;
        n_tag        = r_tag;
        n_len        = r_len;
        n_skip       = r_skip;
        n_offset     = r_offset;
        n_hdr_start  = r_hdr_start;
        n_cand_valid = 1'b0;
        n_cand       = r_cand;

        if (i_accept) begin
            n_hdr_cnt = e_hdr_cnt;
            n_tag     = e_tag;
            n_len     = e_len;
            n_skip    = e_skip;
            n_offset  = e_offset + 32'd1;
            if (e_skip != '0) begin
                n_skip = e_skip - 32'd1;
            end else begin
                if (e_hdr_cnt == 3'd0) begin
                    n_hdr_start = e_offset;
                end
                if (!e_hdr_cnt[2]) begin
                    n_tag     = {i_data_byte, e_tag[31:8]};
                    n_hdr_cnt = e_hdr_cnt + 3'd1;
                    if (e_hdr_cnt == HDR_LAST_TAG) begin
                        n_cand_valid  = 1'b1;
                        n_cand.tag    = n_tag;
                        n_cand.offset = n_hdr_start;
                    end
                end else begin
                    n_len = {i_data_byte, e_len[31:8]};
                    if (e_hdr_cnt == HDR_LAST_LEN) begin
                        n_skip    = n_len;
                        n_hdr_cnt = 3'd0;
                    end else begin
                        n_hdr_cnt = e_hdr_cnt + 3'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt    <= '0;
            r_tag        <= '0;
            r_len        <= '0;
            r_skip       <= '0;
            r_offset     <= '0;
            r_hdr_start  <= '0;
            r_cand_valid <= 1'b0;
        end else begin
            r_hdr_cnt    <= n_hdr_cnt;
            r_tag        <= n_tag;
            r_len        <= n_len;
            r_skip       <= n_skip;
            r_offset     <= n_offset;
            r_hdr_start  <= n_hdr_start;
            r_cand_valid <= n_cand_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
    end

    assign o_cand_valid = r_cand_valid;
    assign o_cand       = r_cand;

    // a completed tag leaves the walker on the first length byte
    a_cand_hdr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cand_valid |-> (r_hdr_cnt == 3'd4))
        else $error("candidate without header count 4");

    // payload skip only runs between headers
    a_skip_idle_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skip != '0) |-> (r_hdr_cnt == 3'd0))
        else $error("skip active inside a header");

endmodule

### rtl/cwuts_match.sv
// Known-tag compare on the registered candidate; passes unknown tags on to the output queue.
// Uses the tag table from cwuts_pkg.
module cwuts_match
    import cwuts_pkg::*;
(
    input  logic  i_cand_valid,
    input  t_cand i_cand,
    output logic  o_push,
    output t_cand o_push_data
);

    assign o_push      = i_cand_valid && !tag_is_known(i_cand.tag);
    assign o_push_data = i_cand;

endmodule

### rtl/cwuts_out_q.sv
// Two-entry result queue that decouples the scanner from the receiver.
// Uses t_cand and queue sizing from cwuts_pkg.
module cwuts_out_q
    import cwuts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_cand                 i_push_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_cand                 o_data,
    output logic [OUTQ_CNT_W-1:0] o_count
);

    t_cand                 r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [OUTQ_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [OUTQ_CNT_W-1:0] r_count, n_count;
    logic                  pop;

    assign pop = (r_count != '0) && i_ready;

    function automatic logic [OUTQ_PTR_W-1:0] ptr_inc(input logic [OUTQ_PTR_W-1:0] p);
        return (p == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : p + OUTQ_PTR_W'(1);
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = pop    ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + OUTQ_CNT_W'(i_push) - OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop) |-> (r_count != OUTQ_CNT_W'(OUTQ_DEPTH)))
        else $error("result queue overflow");

endmodule
